>>> design/olit_pkg.sv
package olit_pkg;

    localparam int DefCapacity = 16;

    // Field widths fixed by the transaction format
    localparam int OpW    = 2;
    localparam int PosW   = 5;
    localparam int ValW   = 32;
    localparam int StatW  = 2;
    localparam int CntOutW = 5;
    localparam int InDataW  = 40;
    localparam int OutDataW = 40;

    localparam logic [OpW-1:0] OP_APPEND = 2'd0;
    localparam logic [OpW-1:0] OP_TAKE   = 2'd1;
    localparam logic [OpW-1:0] OP_INSERT = 2'd2;
    localparam logic [OpW-1:0] OP_NONE   = 2'd3;

    localparam logic [StatW-1:0] ST_DONE  = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatW-1:0] ST_FULL  = 2'd2;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic take;
    } t_cell_ctl;

endpackage

>>> design/olit_cell.sv
module olit_cell #(
    parameter int CAPACITY = olit_pkg::DefCapacity,
    parameter int IDX      = 0,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  olit_pkg::t_cell_ctl           i_ctl,
    input  logic [CW-1:0]                 i_pos,
    input  logic [CW-1:0]                 i_count,
    input  logic [olit_pkg::ValW-1:0]     i_value,
    input  logic [olit_pkg::ValW-1:0]     i_left,
    input  logic [olit_pkg::ValW-1:0]     i_right,
    output logic [olit_pkg::ValW-1:0]     o_data
);

    localparam logic [CW-1:0] IdxV  = CW'(IDX);
    localparam logic [CW-1:0] NextV = CW'(IDX + 1);

    logic [olit_pkg::ValW-1:0] r_data;
    logic [olit_pkg::ValW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (IdxV == i_pos) begin
                n_data = i_value;
            end else if (IdxV > i_pos && IdxV <= i_count) begin
                n_data = i_left;
            end
        end else if (i_ctl.take) begin
            if (NextV < i_count) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> design/ordered_list_insert_take.sv
// Bounded ordered list of signed 32-bit words, head at cell 0.
// Input channel (s): one transaction per operation. tuser carries the
// operation (append at tail, take head, insert before position); tdata
// carries position and the value to store.
// Output channel (m): exactly one transaction per accepted input. tdata
// carries the taken value (zero unless a take succeeded) and the element
// count after the operation; tuser carries the status (done, empty on
// take, full and refused).
// Result: registered; it appears in the cycle after the input is accepted.
// Throughput: one operation per cycle while results are taken; every cell
// of the shift chain decides on its own to shift left, shift right, load or
// hold, so the whole chain updates together regardless of position or count.
// Stall: the result register holds while i_m_tready is low, and the input
// side stays ready only if the held result is taken in the same cycle.
// Reset (synchronous, active low): the list empties and no result is
// pending. Cell contents are not cleared; only cells below the count are
// ever read.
module ordered_list_insert_take #(
    parameter int CAPACITY = olit_pkg::DefCapacity
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [4:0] position, [36:5] value_in, [39:37] zero
    input  logic [olit_pkg::InDataW-1:0]      i_s_tdata,
    // [1:0] operation
    input  logic [olit_pkg::OpW-1:0]          i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [31:0] value_out, [36:32] count_after, [39:37] zero
    output logic [olit_pkg::OutDataW-1:0]     o_m_tdata,
    // [1:0] status
    output logic [olit_pkg::StatW-1:0]        o_m_tuser
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > olit_pkg::PosW) ? CW : olit_pkg::PosW;
    localparam logic [CW-1:0] CapV = CW'(CAPACITY);
    localparam int VW = olit_pkg::ValW;

    logic                               accept;
    logic [olit_pkg::PosW-1:0]          in_pos;
    logic [VW-1:0]                      in_value;
    logic [olit_pkg::OpW-1:0]           in_op;

    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic                               r_out_valid;
    logic [VW-1:0]                      r_out_value;
    logic [VW-1:0]                      n_out_value;
    logic [olit_pkg::StatW-1:0]         r_out_status;
    logic [olit_pkg::StatW-1:0]         n_out_status;
    logic [olit_pkg::CntOutW-1:0]       r_out_count;

    logic [PW-1:0]                      pos_w;
    logic [PW-1:0]                      cnt_w;
    logic [CW-1:0]                      eff_pos;
    logic                               full;
    logic                               empty;
    olit_pkg::t_cell_ctl                ctl;

    logic [VW-1:0]                      cell_q [CAPACITY];

    assign in_pos   = i_s_tdata[olit_pkg::PosW-1:0];
    assign in_value = i_s_tdata[olit_pkg::PosW +: VW];
    assign in_op    = i_s_tuser;

    // Accept while nothing is pending or the pending result leaves now
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign full  = (r_count == CapV);
    assign empty = (r_count == '0);

    // Clamp the insert position to the tail
    assign pos_w = PW'(in_pos);
    assign cnt_w = PW'(r_count);

    always_comb begin
        ctl          = '0;
        eff_pos      = r_count;
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = olit_pkg::ST_DONE;
        unique case (in_op)
            olit_pkg::OP_APPEND: begin
                if (full) begin
                    n_out_status = olit_pkg::ST_FULL;
                end else begin
                    ctl.ins = accept;
                    n_count = r_count + CW'(1);
                end
            end
            olit_pkg::OP_INSERT: begin
                if (pos_w < cnt_w) begin
                    eff_pos = pos_w[CW-1:0];
                end
                if (full) begin
                    n_out_status = olit_pkg::ST_FULL;
                end else begin
                    ctl.ins = accept;
                    n_count = r_count + CW'(1);
                end
            end
            olit_pkg::OP_TAKE: begin
                if (empty) begin
                    n_out_status = olit_pkg::ST_EMPTY;
                end else begin
                    ctl.take    = accept;
                    n_out_value = cell_q[0];
                    n_count     = r_count - CW'(1);
                end
            end
            olit_pkg::OP_NONE: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Shift chain: each cell sees its left and right neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VW-1:0] left_d;
        logic [VW-1:0] right_d;
        if (g == 0) begin : g_head
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_q[g+1];
        end
        olit_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g),
            .CW       (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_pos   (eff_pos),
            .i_count (r_count),
            .i_value (in_value),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_count  <= olit_pkg::CntOutW'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_count, r_out_value};
    assign o_m_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapV)
        else $error("count exceeds capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_tvalid)
        else $error("accepted transaction produced no result");

    a_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_op == olit_pkg::OP_TAKE && empty |=>
            o_m_tuser == olit_pkg::ST_EMPTY && r_count == '0)
        else $error("take from empty list mishandled");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_out_count == olit_pkg::CntOutW'(r_count))
        else $error("reported count disagrees with list count");
`endif

endmodule
